>>> design/link_timeout_and_fall_watchdog_assert.svh
// Assertion macros for the link timeout and fall watchdog checker.
`ifndef LINK_TIMEOUT_AND_FALL_WATCHDOG_ASSERT_SVH
`define LINK_TIMEOUT_AND_FALL_WATCHDOG_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define LFW_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfw: implication failed");

// Next-cycle implication, masked while reset is held.
`define LFW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfw: next-cycle implication failed");

`endif

>>> design/lfw_pkg.sv
// Shared types, widths and codes for the link timeout and fall watchdog.
package lfw_pkg;

    localparam int ELAPSED_W  = 16;
    localparam int TMO_W      = 16;
    localparam int AGE_W      = 16;
    localparam int MAX_AGE_W  = 15;
    localparam int THR_W      = 15;
    localparam int ACCEL_W    = 16;
    localparam int SQ_W       = 2 * ACCEL_W;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int CMP_W      = (ELAPSED_W > TMO_W) ? ELAPSED_W : TMO_W;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    localparam logic [MAX_AGE_W-1:0] RST_MAX_AGE  = MAX_AGE_W'(20);
    localparam logic [TMO_W-1:0]     RST_CMD_TMO  = TMO_W'(50);
    localparam logic [TMO_W-1:0]     RST_HB_TMO   = TMO_W'(500);
    localparam logic [THR_W-1:0]     RST_FALL_THR = THR_W'(7526);

    localparam logic MODE_SAFE      = 1'b0;
    localparam logic MODE_EMERGENCY = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_FRAME     = 3'd1,
        CMD_DRY_RUN   = 3'd2,
        CMD_HEARTBEAT = 3'd3,
        CMD_IMU       = 3'd4,
        CMD_CHECK     = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_AGE  = 3'd0,
        REG_CMD_TMO  = 3'd1,
        REG_HB_TMO   = 3'd2,
        REG_FALL_THR = 3'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        REASON_DRY_RUN     = 2'd0,
        REASON_CMD_TIMEOUT = 2'd1,
        REASON_HB_TIMEOUT  = 2'd2,
        REASON_FALL        = 2'd3
    } t_reason;

    typedef struct packed {
        logic [MAX_AGE_W-1:0] max_age;
        logic [TMO_W-1:0]     cmd_tmo;
        logic [TMO_W-1:0]     hb_tmo;
        logic [THR_W-1:0]     fall_thr;
    } t_cfg;

    typedef struct packed {
        logic    hit;
        t_reason reason;
    } t_check;

endpackage

>>> design/lfw_cfg.sv
// Configuration register file of the watchdog.
module lfw_cfg
    import lfw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_age  <= RST_MAX_AGE;
            r_cfg.cmd_tmo  <= RST_CMD_TMO;
            r_cfg.hb_tmo   <= RST_HB_TMO;
            r_cfg.fall_thr <= RST_FALL_THR;
        end else if (i_wr_en) begin
            unique case (t_reg_idx'(i_index))
                REG_MAX_AGE:  r_cfg.max_age  <= i_data[MAX_AGE_W-1:0];
                REG_CMD_TMO:  r_cfg.cmd_tmo  <= i_data[TMO_W-1:0];
                REG_HB_TMO:   r_cfg.hb_tmo   <= i_data[TMO_W-1:0];
                REG_FALL_THR: r_cfg.fall_thr <= i_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/lfw_monitor.sv
// Elapsed-time counters, dry-run flag and the safety check decision.
module lfw_monitor
    import lfw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [AGE_W-1:0] i_age,
    input  t_cfg                    i_cfg,
    output t_check                  o_check
);

    logic [ELAPSED_W-1:0] r_cmd_elapsed, n_cmd_elapsed;
    logic [ELAPSED_W-1:0] r_hb_elapsed,  n_hb_elapsed;
    logic                 r_dry_seen,    n_dry_seen;
    logic                 fresh;

    // Negative ages count as fresh, hence the signed compare.
    assign fresh = i_age <= $signed({1'b0, i_cfg.max_age});

    always_comb begin
        n_cmd_elapsed = r_cmd_elapsed;
        n_hb_elapsed  = r_hb_elapsed;
        n_dry_seen    = r_dry_seen;
        case (t_cmd'(i_cmd))
            CMD_TICK: begin
                if (r_cmd_elapsed != ELAPSED_MAX) n_cmd_elapsed = r_cmd_elapsed + 1'b1;
                if (r_hb_elapsed != ELAPSED_MAX)  n_hb_elapsed  = r_hb_elapsed + 1'b1;
            end
            CMD_FRAME:     if (fresh) n_cmd_elapsed = '0;
            CMD_DRY_RUN:   if (fresh) n_dry_seen = 1'b1;
            CMD_HEARTBEAT: n_hb_elapsed = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_elapsed <= '0;
            r_hb_elapsed  <= '0;
            r_dry_seen    <= 1'b0;
        end else if (i_en) begin
            r_cmd_elapsed <= n_cmd_elapsed;
            r_hb_elapsed  <= n_hb_elapsed;
            r_dry_seen    <= n_dry_seen;
        end
    end

    // First failing reason wins.
    always_comb begin
        o_check.hit    = 1'b0;
        o_check.reason = REASON_DRY_RUN;
        if (t_cmd'(i_cmd) == CMD_CHECK) begin
            if (!r_dry_seen) begin
                o_check.hit = 1'b1;
            end else if (CMP_W'(r_cmd_elapsed) > CMP_W'(i_cfg.cmd_tmo)) begin
                o_check.hit    = 1'b1;
                o_check.reason = REASON_CMD_TIMEOUT;
            end else if (CMP_W'(r_hb_elapsed) > CMP_W'(i_cfg.hb_tmo)) begin
                o_check.hit    = 1'b1;
                o_check.reason = REASON_HB_TIMEOUT;
            end
        end
    end

endmodule

>>> design/lfw_fall.sv
// Fall detector: registered squares, then sum and compare against threshold squared.
module lfw_fall
    import lfw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic signed [ACCEL_W-1:0] i_ax,
    input  logic signed [ACCEL_W-1:0] i_ay,
    input  logic signed [ACCEL_W-1:0] i_az,
    input  logic [THR_W-1:0]          i_thr,
    output logic                      o_fall
);

    logic signed [SQ_W-1:0] prod_x, prod_y, prod_z;
    logic [SQ_W-1:0]        r_sq_x, r_sq_y, r_sq_z;
    logic [THR_SQ_W-1:0]    r_thr_sq;
    logic [SUM_W-1:0]       mag_sq;

    // Squares are never negative, so the signed products read as unsigned.
    assign prod_x = i_ax * i_ax;
    assign prod_y = i_ay * i_ay;
    assign prod_z = i_az * i_az;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sq_x   <= prod_x;
            r_sq_y   <= prod_y;
            r_sq_z   <= prod_z;
            r_thr_sq <= i_thr * i_thr;
        end
    end

    assign mag_sq = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
    assign o_fall = mag_sq > SUM_W'(r_thr_sq);

endmodule

>>> design/link_timeout_and_fall_watchdog.sv
// Link timeout and fall watchdog top level.
//
// Input channel (i_in_valid / o_in_ready) carries one event per transfer:
// a 1 ms tick, a command frame, a dry-run frame, a heartbeat, an IMU sample
// or a safety check. Output channel (o_out_valid / i_out_ready) carries a
// forced mode and reason; only a fall or a failing check produces a transfer.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes one of four limits by index; unknown indexes are dropped.
//
// Three register stages: input register, square/decision register, result
// register. An event passes through them in that order, and a new event
// is taken every cycle while the pipeline is not stalled.
// When the receiver stalls, the result is held and the stages behind it
// fill; o_in_ready drops only once all three are occupied.
// Reset clears the counters, the dry-run flag and all stage valids, and
// reloads the limits with their default values.
module link_timeout_and_fall_watchdog
    import lfw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [AGE_W-1:0]   i_frame_age_ms,
    input  logic signed [ACCEL_W-1:0] i_accel_x,
    input  logic signed [ACCEL_W-1:0] i_accel_y,
    input  logic signed [ACCEL_W-1:0] i_accel_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_mode,
    output logic [1:0]                o_reason,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg   cfg;
    t_check check;
    logic   fall;
    logic   s1_free, s2_free, s3_free;

    logic                      r_s1_valid;
    logic [CMD_W-1:0]          r_s1_cmd;
    logic signed [AGE_W-1:0]   r_s1_age;
    logic signed [ACCEL_W-1:0] r_s1_ax, r_s1_ay, r_s1_az;

    logic   r_s2_valid;
    logic   r_s2_imu;
    t_check r_s2_check;

    logic    r_out_valid;
    logic    r_out_mode;
    t_reason r_out_reason;

    assign s3_free    = !r_out_valid || i_out_ready;
    assign s2_free    = !r_s2_valid || s3_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free;
    assign o_cfg_ready = 1'b1;

    lfw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lfw_monitor u_monitor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_s1_valid && s2_free),
        .i_cmd   (r_s1_cmd),
        .i_age   (r_s1_age),
        .i_cfg   (cfg),
        .o_check (check)
    );

    lfw_fall u_fall (
        .i_clk  (i_clk),
        .i_load (s2_free),
        .i_ax   (r_s1_ax),
        .i_ay   (r_s1_ay),
        .i_az   (r_s1_az),
        .i_thr  (cfg.fall_thr),
        .o_fall (fall)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_s1_cmd <= i_command;
            r_s1_age <= i_frame_age_ms;
            r_s1_ax  <= i_accel_x;
            r_s1_ay  <= i_accel_y;
            r_s1_az  <= i_accel_z;
        end
    end

    // Decision stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_imu   <= t_cmd'(r_s1_cmd) == CMD_IMU;
            r_s2_check <= check;
        end
    end

    // Result register; events without a result leave it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_free) begin
            r_out_valid <= r_s2_valid && (r_s2_check.hit || (r_s2_imu && fall));
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free && r_s2_valid) begin
            if (r_s2_check.hit) begin
                r_out_mode   <= MODE_SAFE;
                r_out_reason <= r_s2_check.reason;
            end else begin
                r_out_mode   <= MODE_EMERGENCY;
                r_out_reason <= REASON_FALL;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mode      = r_out_mode;
    assign o_reason    = r_out_reason;

endmodule

>>> design/lfw_checker.sv
// Port-level checker for the watchdog, bound to the top level.
`include "link_timeout_and_fall_watchdog_assert.svh"

module lfw_checker
    import lfw_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [CMD_W-1:0]          i_command,
    input logic signed [AGE_W-1:0]   i_frame_age_ms,
    input logic signed [ACCEL_W-1:0] i_accel_x,
    input logic signed [ACCEL_W-1:0] i_accel_y,
    input logic signed [ACCEL_W-1:0] i_accel_z,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic                      o_mode,
    input logic [1:0]                o_reason,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready,
    input logic [CFG_IDX_W-1:0]      i_cfg_index,
    input logic [CFG_DATA_W-1:0]     i_cfg_data
);

    // A stalled result holds.
    `LFW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_mode) && $stable(o_reason))

    // Back-pressure reaches the input only through a stalled result.
    `LFW_ASSERT_IMPLY(a_bp_source, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // Emergency goes with a fall, and only with a fall.
    `LFW_ASSERT_IMPLY(a_mode_reason, i_clk, i_rst_n, o_out_valid, (o_mode == MODE_EMERGENCY) == (o_reason == REASON_FALL))

    // Leaving reset: pipeline empty and ready for a transfer.
    `LFW_ASSERT_IMPLY(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid && o_in_ready)

endmodule

bind link_timeout_and_fall_watchdog lfw_checker u_lfw_checker (.*);

>>> verif/tb_link_timeout_and_fall_watchdog.sv
// Self-checking testbench for the link timeout and fall watchdog.
`timescale 1ns / 100ps

import lfw_pkg::*;

typedef struct packed {
    logic    mode;
    t_reason reason;
} t_alarm;

// Tracks watchdog state and the alarms the block owes.
class alarm_book;
    logic [MAX_AGE_W-1:0] max_age;
    logic [TMO_W-1:0]     cmd_tmo;
    logic [TMO_W-1:0]     hb_tmo;
    logic [THR_W-1:0]     fall_thr;
    logic [ELAPSED_W-1:0] cmd_elapsed;
    logic [ELAPSED_W-1:0] hb_elapsed;
    logic                 dry_run_ok;
    t_alarm               pending[$];
    int                   faults;
    int                   events_seen;
    int                   alarms_seen;

    function new();
        max_age     = RST_MAX_AGE;
        cmd_tmo     = RST_CMD_TMO;
        hb_tmo      = RST_HB_TMO;
        fall_thr    = RST_FALL_THR;
        cmd_elapsed = '0;
        hb_elapsed  = '0;
        dry_run_ok  = 1'b0;
        faults      = 0;
        events_seen = 0;
        alarms_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MAX_AGE:  max_age  = data[MAX_AGE_W-1:0];
            REG_CMD_TMO:  cmd_tmo  = data[TMO_W-1:0];
            REG_HB_TMO:   hb_tmo   = data[TMO_W-1:0];
            REG_FALL_THR: fall_thr = data[THR_W-1:0];
            default: ;
        endcase
    endfunction

    function void add_alarm(logic mode, t_reason reason);
        t_alarm a;
        a.mode   = mode;
        a.reason = reason;
        pending.push_back(a);
    endfunction

    function void take_event(logic [CMD_W-1:0] cmd, logic signed [AGE_W-1:0] age,
                             logic signed [ACCEL_W-1:0] ax, logic signed [ACCEL_W-1:0] ay,
                             logic signed [ACCEL_W-1:0] az);
        longint mag2;
        longint lim2;
        bit     fresh;
        events_seen++;
        fresh = (longint'(age) <= longint'(max_age));
        mag2  = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
              + longint'(az) * longint'(az);
        lim2  = longint'(fall_thr) * longint'(fall_thr);
        case (cmd)
            CMD_TICK: begin
                // hold both counters once they reach full scale
                if (cmd_elapsed != ELAPSED_MAX) cmd_elapsed++;
                if (hb_elapsed != ELAPSED_MAX) hb_elapsed++;
            end
            CMD_FRAME:     if (fresh) cmd_elapsed = '0;
            CMD_DRY_RUN:   if (fresh) dry_run_ok = 1'b1;
            CMD_HEARTBEAT: hb_elapsed = '0;
            CMD_IMU:       if (mag2 > lim2) add_alarm(MODE_EMERGENCY, REASON_FALL);
            CMD_CHECK: begin
                if (!dry_run_ok) add_alarm(MODE_SAFE, REASON_DRY_RUN);
                else if (cmd_elapsed > cmd_tmo) add_alarm(MODE_SAFE, REASON_CMD_TIMEOUT);
                else if (hb_elapsed > hb_tmo) add_alarm(MODE_SAFE, REASON_HB_TIMEOUT);
            end
            default: ;
        endcase
    endfunction

    function void match_alarm(logic mode, logic [1:0] reason);
        t_alarm want;
        if (pending.size() == 0) begin
            if (faults < 20)
                $display("%0t: unexpected alarm, expected none, got mode %0d reason %0d",
                         $time, mode, reason);
            faults++;
            return;
        end
        want = pending.pop_front();
        alarms_seen++;
        if (mode !== want.mode) begin
            if (faults < 20)
                $display("%0t: mode mismatch, expected %0d, got %0d", $time, want.mode, mode);
            faults++;
        end
        if (reason !== want.reason) begin
            if (faults < 20)
                $display("%0t: reason mismatch, expected %0d, got %0d",
                         $time, want.reason, reason);
            faults++;
        end
    endfunction
endclass

module tb_link_timeout_and_fall_watchdog;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI    = 3'd7;
    localparam int               REG_SPARE_FIRST = 4;
    localparam int               REG_SPARE_LAST  = 7;
    localparam int               STALL_NONE      = 0;
    localparam int               STALL_RANDOM    = 1;
    localparam int               STALL_HEAVY     = 2;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_command      = '0;
    logic signed [AGE_W-1:0]   i_frame_age_ms = '0;
    logic signed [ACCEL_W-1:0] i_accel_x      = '0;
    logic signed [ACCEL_W-1:0] i_accel_y      = '0;
    logic signed [ACCEL_W-1:0] i_accel_z      = '0;
    logic                      o_out_valid;
    logic                      i_out_ready    = 1'b0;
    logic                      o_mode;
    logic [1:0]                o_reason;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data     = '0;

    alarm_book book = new();
    int        burst_left  = 0;
    int        stall_style = STALL_NONE;
    int        stall_left  = 0;
    int        settings_used = 0;

    link_timeout_and_fall_watchdog dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.match_alarm(o_mode, o_reason);
    end

    // Receiver: switch between free flow, light stalls and heavy stalls.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_left  <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_NONE:   i_out_ready <= 1'b1;
            STALL_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
            default:      i_out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    function automatic logic [15:0] clamp16(int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [AGE_W-1:0] age,
                              input logic [ACCEL_W-1:0] ax, input logic [ACCEL_W-1:0] ay,
                              input logic [ACCEL_W-1:0] az);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_frame_age_ms <= age;
        i_accel_x      <= ax;
        i_accel_y      <= ay;
        i_accel_z      <= az;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.take_event(cmd, age, ax, ay, az);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [AGE_W-1:0] age);
        send_event(cmd, age, '0, '0, '0);
    endtask

    // Drain: drop valid, wait for every owed alarm, then let the pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (book.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        book.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] age, input logic [CFG_DATA_W-1:0] ctmo,
                              input logic [CFG_DATA_W-1:0] htmo, input logic [CFG_DATA_W-1:0] thr);
        settle();
        write_limit(REG_MAX_AGE, age);
        write_limit(REG_CMD_TMO, ctmo);
        // an index past the last register must be dropped
        write_limit(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                    CFG_DATA_W'($urandom));
        write_limit(REG_HB_TMO, htmo);
        write_limit(REG_FALL_THR, thr);
        settings_used++;
    endtask

    task automatic random_event();
        int                 pick;
        int                 lim;
        int                 v;
        logic [CMD_W-1:0]   cmd;
        logic [AGE_W-1:0]   age;
        logic [ACCEL_W-1:0] acc[3];
        pick = $urandom_range(0, 99);
        if (pick < 35) cmd = CMD_TICK;
        else if (pick < 47) cmd = CMD_FRAME;
        else if (pick < 52) cmd = CMD_DRY_RUN;
        else if (pick < 62) cmd = CMD_HEARTBEAT;
        else if (pick < 82) cmd = CMD_IMU;
        else if (pick < 97) cmd = CMD_CHECK;
        else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));

        pick = $urandom_range(0, 9);
        if (pick < 5) age = clamp16(int'(book.max_age) + int'($urandom_range(0, 4)) - 2);
        else if (pick < 8) age = clamp16(int'($urandom_range(0, 150)) - 50);
        else age = AGE_W'($urandom);

        lim = book.fall_thr;
        foreach (acc[i]) acc[i] = ACCEL_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            // one axis around the threshold, the others quiet
            foreach (acc[i])
                acc[i] = $urandom_range(0, 1) ? '0 : clamp16(int'($urandom_range(0, 6)) - 3);
            v = lim + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1)) v = -v;
            acc[$urandom_range(0, 2)] = clamp16(v);
        end else if (pick < 7) begin
            foreach (acc[i]) acc[i] = clamp16(int'($urandom_range(0, lim)) - lim / 2);
        end
        send_event(cmd, age, acc[0], acc[1], acc[2]);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset limits, validation, unused codes, fall edges.
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_DRY_RUN, 16'd21);
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_DRY_RUN, 16'h8000);
        send_cmd(CMD_CHECK, '0);
        send_event(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(CMD_SPARE_HI, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_event(CMD_IMU, '0, '0, '0, '0);
        send_event(CMD_IMU, '0, 16'd7526, '0, '0);
        send_event(CMD_IMU, '0, '0, 16'(-7527), '0);
        send_event(CMD_IMU, '0, 16'd4345, 16'd4345, 16'd4345);
        send_event(CMD_IMU, '0, 16'(-4346), 16'd4346, 16'(-4346));
        send_event(CMD_IMU, '0, 16'h8000, 16'h8000, 16'h8000);
        send_event(CMD_IMU, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF);

        // Directed: timeout boundaries and stale frames.
        set_limits(16'd20, 16'd2, 16'd4, 16'd7526);
        repeat (3) send_cmd(CMD_TICK, '0);
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_FRAME, 16'd21);
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_FRAME, 16'd20);
        send_cmd(CMD_CHECK, '0);
        repeat (2) send_cmd(CMD_TICK, '0);
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_HEARTBEAT, '0);
        send_cmd(CMD_CHECK, '0);

        // Largest timeouts: a run of ticks never trips either one.
        set_limits(16'd20, 16'd65534, 16'd65534, 16'd7526);
        send_cmd(CMD_HEARTBEAT, '0);
        send_cmd(CMD_FRAME, '0);
        repeat (40) send_cmd(CMD_TICK, '0);
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_FRAME, '0);
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_TICK, '0);
        send_cmd(CMD_CHECK, '0);
        send_cmd(CMD_HEARTBEAT, '0);
        send_cmd(CMD_CHECK, '0);

        // Random phases: low extremes, high extremes with masking, then mixed.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0)
                set_limits('0, '0, '0, '0);
            else if (phase == 1)
                set_limits(16'hFFFF, 16'd65534, 16'd65534, 16'hFFFF);
            else
                set_limits(CFG_DATA_W'($urandom_range(0, 60)),
                           CFG_DATA_W'($urandom_range(0, 30)),
                           CFG_DATA_W'($urandom_range(0, 60)),
                           CFG_DATA_W'($urandom_range(1, 32767)));
            repeat (300) random_event();
        end

        settle();
        $display("Covered %0d events over %0d limit settings, with timeout and fall edges;",
                 book.events_seen, settings_used);
        $display("checked %0d alarms, %0d mismatches.", book.alarms_seen, book.faults);
        if (book.faults == 0)
            $display("link_timeout_and_fall_watchdog test passed");
        else
            $display("link_timeout_and_fall_watchdog test failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("link_timeout_and_fall_watchdog test failed");
        $finish;
    end

endmodule
